// ===== design/bphd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the button press/hold debouncer: payload structs, config struct,
// phase and event codes, register indexes. No dependencies.
package bphd_pkg;

    localparam int STAMP_W    = 32;
    localparam int IDENT_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_IDENT  = 2'd3;

    // Register values after reset
    localparam logic                  RST_PRESS_LEVEL   = 1'b1;
    localparam logic [STAMP_W-1:0]    RST_DEBOUNCE_TIME = 32'd20000;
    localparam logic [STAMP_W-1:0]    RST_HOLD_TIME     = 32'd500000;
    localparam logic [IDENT_W-1:0]    RST_BUTTON_IDENT  = 12'd0;

    // Event codes reported with each result
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PRESS   = 2'd1;
    localparam logic [1:0] EV_HOLD    = 2'd2;
    localparam logic [1:0] EV_RELEASE = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_HELD     = 2'd2,
        PH_DEBOUNCE = 2'd3
    } phase_t;

    typedef struct packed {
        logic               pin_level;
        logic [STAMP_W-1:0] now_us;
    } sample_t;

    typedef struct packed {
        logic [1:0]         event_code;
        logic [IDENT_W-1:0] event_ident;
        logic               changed;
    } report_t;

    typedef struct packed {
        logic               press_level;
        logic [STAMP_W-1:0] debounce_time;
        logic [STAMP_W-1:0] hold_time;
        logic [IDENT_W-1:0] button_ident;
    } cfg_t;

endpackage

// ===== design/bphd_fsm.sv =====
`timescale 1ns / 1ps
// Button phase tracker: polarity fix, elapsed time compare, four-phase machine.
// Depends on bphd_pkg.
module bphd_fsm #(
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  bphd_pkg::sample_t sample,
    input  bphd_pkg::cfg_t    cfg,
    output bphd_pkg::report_t report
);
    import bphd_pkg::*;

    localparam int WIDE_W = TIME_BITS + STAMP_W;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [TIME_BITS-1:0]   entry_reg;
    logic [TIME_BITS-1:0]   entry_next;
    logic [WIDE_W-1:0]      now_wide;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   elapsed;
    logic [WIDE_W-1:0]      elapsed_wide;
    logic [WIDE_W-1:0]      hold_wide;
    logic [WIDE_W-1:0]      deb_wide;
    logic                   pressed;
    logic                   hold_hit;
    logic                   deb_hit;
    logic [1:0]             ev;

    // Timestamp fitted to the tracker's time width (truncate or zero-extend)
    assign now_wide = {{TIME_BITS{1'b0}}, sample.now_us};
    assign now_t    = now_wide[TIME_BITS-1:0];

    // Modular elapsed time and threshold compares
    assign elapsed      = now_t - entry_reg;
    assign elapsed_wide = {{STAMP_W{1'b0}}, elapsed};
    assign hold_wide    = {{TIME_BITS{1'b0}}, cfg.hold_time};
    assign deb_wide     = {{TIME_BITS{1'b0}}, cfg.debounce_time};
    assign hold_hit     = elapsed_wide >= hold_wide;
    assign deb_hit      = elapsed_wide >= deb_wide;

    // 1 always means pressed after polarity correction
    assign pressed = sample.pin_level ^ ~cfg.press_level;

    // State registers, advanced once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            entry_reg <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            entry_reg <= entry_next;
        end
    end

    // Next phase and event
    always_comb
    begin
        phase_next = phase_reg;
        entry_next = entry_reg;
        ev         = EV_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next = PH_PRESSED;
                    entry_next = now_t;
                    ev         = EV_PRESS;
                end
            end
            PH_PRESSED:
            begin
                priority if (!pressed)
                begin
                    phase_next = PH_DEBOUNCE;
                    entry_next = now_t;
                end
                else if (hold_hit)
                begin
                    phase_next = PH_HELD;
                    ev         = EV_HOLD;
                end
            end
            PH_HELD:
            begin
                if (!pressed)
                begin
                    phase_next = PH_DEBOUNCE;
                    entry_next = now_t;
                end
            end
            PH_DEBOUNCE:
            begin
                // bounce goes back to held, entry time kept
                priority if (pressed)
                begin
                    phase_next = PH_HELD;
                end
                else if (deb_hit)
                begin
                    phase_next = PH_IDLE;
                    ev         = EV_RELEASE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign report.event_code  = ev;
    assign report.event_ident = cfg.button_ident;
    assign report.changed     = (ev == EV_PRESS) || (ev == EV_RELEASE);

    // Checks
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(phase_reg) && $stable(entry_reg))
        else $error("phase state moved without a transaction");

    a_press_entry: assert property (@(posedge clk) disable iff (!rst_n)
        take && report.event_code == EV_PRESS
        |=> phase_reg == PH_PRESSED && entry_reg == $past(now_t))
        else $error("press did not record entry time");

    a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take && report.event_code == EV_RELEASE |=> phase_reg == PH_IDLE)
        else $error("release did not return to idle");

    a_hold_from_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        take && report.event_code == EV_HOLD |=> phase_reg == PH_HELD && $stable(entry_reg))
        else $error("hold event with wrong phase update");

endmodule

// ===== design/button_press_hold_debounce_top.sv =====
`timescale 1ns / 1ps
// Top level of the button press/hold debouncer: config registers, output register.
// Depends on bphd_pkg and bphd_fsm.
//
// Usage:
//   Sample channel (sample_valid/sample_ready/sample_data) carries one pin sample
//   and its microsecond timestamp per transaction. Report channel
//   (report_valid/report_ready/report_data) returns exactly one report per
//   sample: event code (none, press, hold, release), button identifier and a
//   changed flag for press or release.
//   The report is registered and presented in the cycle after the sample is taken.
//   Throughput: one sample per cycle when not stalled; the phase update is one
//   pass of subtract, compare and transition logic ahead of the report register.
//   Stall: while a report waits and report_ready is low, sample_ready is low;
//   a report taken in a cycle frees the register for a sample in that same cycle.
//   Configuration: cfg_we writes cfg_data to the cfg_index register (polarity,
//   debounce/hold time, ident); the user must write only while idle (unenforced).
//   Reset: phase idle, entry time zero, registers at their defaults
//   (high pin level pressed, 20000 us debounce, 500000 us hold, identifier 0),
//   no report.
module button_press_hold_debounce_top #(
    parameter int TIME_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  bphd_pkg::sample_t                    sample_data,
    output logic                                 report_valid,
    input  logic                                 report_ready,
    output bphd_pkg::report_t                    report_data,
    input  logic                                 cfg_we,
    input  logic [bphd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bphd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bphd_pkg::*;

    cfg_t    cfg_reg;
    report_t report_comb;
    report_t report_reg;
    logic    report_valid_reg;
    logic    take;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_level   <= RST_PRESS_LEVEL;
            cfg_reg.debounce_time <= RST_DEBOUNCE_TIME;
            cfg_reg.hold_time     <= RST_HOLD_TIME;
            cfg_reg.button_ident  <= RST_BUTTON_IDENT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRESS_LEVEL:   cfg_reg.press_level   <= cfg_data[0];
                CFG_DEBOUNCE_TIME: cfg_reg.debounce_time <= cfg_data[STAMP_W-1:0];
                CFG_HOLD_TIME:     cfg_reg.hold_time     <= cfg_data[STAMP_W-1:0];
                CFG_BUTTON_IDENT:  cfg_reg.button_ident  <= cfg_data[IDENT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: take a sample when the report register is empty or draining
    assign sample_ready = !report_valid_reg || report_ready;
    assign take         = sample_valid && sample_ready;

    bphd_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .sample (sample_data),
        .cfg    (cfg_reg),
        .report (report_comb)
    );

    // Report register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            report_valid_reg <= take;
        end
    end

    // Report register: payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            report_reg <= report_comb;
        end
    end

    assign report_valid = report_valid_reg;
    assign report_data  = report_reg;

    // Checks
    a_report_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> report_valid_reg)
        else $error("accepted sample produced no report");

    a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid_reg && !report_ready |=> report_valid_reg && $stable(report_reg))
        else $error("stalled report changed or vanished");

    a_changed_code: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid_reg |-> report_reg.changed ==
            ((report_reg.event_code == EV_PRESS) || (report_reg.event_code == EV_RELEASE)))
        else $error("changed flag disagrees with event code");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for button_press_hold_debounce_top: a directed table, then random
// button traffic under several idling mixes. Depends on bphd_pkg and the design sources.
module testbench;
    import bphd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BLOCKS  = 12;
    localparam int BLOCK_ITEMS    = 160;

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

    // One line of the directed table: a sample (optionally with a typed result) or a write
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        sample_t               sample;
        logic                  typed;
        report_t               want;
    } row_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    sample_t               sample_data  = '0;
    logic                  report_valid;
    logic                  report_ready = 1'b0;
    report_t               report_data;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Typed result travelling alongside the sample in flight
    logic    typed_valid  = 1'b0;
    report_t typed_report = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    // Behavioural copy of the debouncer
    cfg_t               model_cfg;
    phase_t             model_phase;
    logic [STAMP_W-1:0] model_entry;
    report_t            pending_events[$];

    // Stimulus side view of the settings and of the simulated button
    logic               drv_high     = RST_PRESS_LEVEL;
    logic [STAMP_W-1:0] drv_debounce = RST_DEBOUNCE_TIME;
    logic [STAMP_W-1:0] drv_hold     = RST_HOLD_TIME;
    logic [STAMP_W-1:0] drv_clock    = '0;
    logic               drv_pressed  = 1'b0;

    row_t steps[$];

    button_press_hold_debounce_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report_data  (report_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Phase update for one sample; returns the event it causes
    function automatic report_t button_event(input sample_t s);
        logic               pressed;
        logic [STAMP_W-1:0] since;
        logic [1:0]         code;
        report_t            r;
        pressed = s.pin_level ^ ~model_cfg.press_level;
        since   = s.now_us - model_entry;   // wraps modulo 2^32
        code    = EV_NONE;
        case (model_phase)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    model_phase = PH_PRESSED;
                    model_entry = s.now_us;
                    code        = EV_PRESS;
                end
            end
            PH_PRESSED:
            begin
                if (!pressed)
                begin
                    model_phase = PH_DEBOUNCE;
                    model_entry = s.now_us;
                end
                else if (since >= model_cfg.hold_time)
                begin
                    model_phase = PH_HELD;
                    code        = EV_HOLD;
                end
            end
            PH_HELD:
            begin
                if (!pressed)
                begin
                    model_phase = PH_DEBOUNCE;
                    model_entry = s.now_us;
                end
            end
            default:
            begin
                // a bounce goes back to held and keeps the entry time
                if (pressed)
                    model_phase = PH_HELD;
                else if (since >= model_cfg.debounce_time)
                begin
                    model_phase = PH_IDLE;
                    code        = EV_RELEASE;
                end
            end
        endcase
        r.event_code  = code;
        r.event_ident = model_cfg.button_ident;
        r.changed     = (code == EV_PRESS) || (code == EV_RELEASE);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Model update and comparison, sampled on the same edge the design sees
    always @(posedge clk)
    begin : report_check
        report_t want;
        if (!rst_n)
        begin
            model_cfg.press_level   = RST_PRESS_LEVEL;
            model_cfg.debounce_time = RST_DEBOUNCE_TIME;
            model_cfg.hold_time     = RST_HOLD_TIME;
            model_cfg.button_ident  = RST_BUTTON_IDENT;
            model_phase             = PH_IDLE;
            model_entry             = '0;
        end
        else
        begin
            if (report_valid && report_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    fail_count++;
                    $error("report transaction with no sample awaiting one");
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("event_code", 32'(want.event_code),
                                32'(report_data.event_code));
                    check_field("event_ident", 32'(want.event_ident),
                                32'(report_data.event_ident));
                    check_field("changed", 32'(want.changed), 32'(report_data.changed));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PRESS_LEVEL:   model_cfg.press_level   = cfg_data[0];
                    CFG_DEBOUNCE_TIME: model_cfg.debounce_time = cfg_data;
                    CFG_HOLD_TIME:     model_cfg.hold_time     = cfg_data;
                    CFG_BUTTON_IDENT:  model_cfg.button_ident  = cfg_data[IDENT_W-1:0];
                    default: ;
                endcase
            end
            if (sample_valid && sample_ready)
            begin
                want = button_event(sample_data);
                pending_events.push_back(typed_valid ? typed_report : want);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        report_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (sample_valid && sample_ready) || (report_valid && report_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("button_press_hold_debounce_top verification failed");
            $finish;
        end
    end

    // Offer one sample, with random idle cycles ahead of it, until it is taken
    task automatic push_sample(input sample_t s, input logic with_typed, input report_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= s;
        typed_valid  <= with_typed;
        typed_report <= want;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // Hold the sender off until every outstanding report has been taken
    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_PRESS_LEVEL:   drv_high     = val[0];
            CFG_DEBOUNCE_TIME: drv_debounce = val;
            CFG_HOLD_TIME:     drv_hold     = val;
            default: ;
        endcase
    endtask

    function automatic row_t sample_row(input logic pin, input logic [STAMP_W-1:0] stamp);
        row_t r;
        r                  = '0;
        r.kind             = ROW_SAMPLE;
        r.sample.pin_level = pin;
        r.sample.now_us    = stamp;
        return r;
    endfunction

    function automatic row_t typed_row(input logic pin, input logic [STAMP_W-1:0] stamp,
                                       input logic [1:0] code, input logic [IDENT_W-1:0] ident,
                                       input logic chg);
        row_t r;
        r                  = sample_row(pin, stamp);
        r.typed            = 1'b1;
        r.want.event_code  = code;
        r.want.event_ident = ident;
        r.want.changed     = chg;
        return r;
    endfunction

    function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
        row_t r;
        r           = '0;
        r.kind      = ROW_WRITE;
        r.reg_index = idx;
        r.reg_value = val;
        return r;
    endfunction

    // Threshold values, extremes included
    function automatic logic [STAMP_W-1:0] pick_span();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 32'd1;
            2:       return $urandom_range(2, 64);
            3:       return $urandom_range(65, 100000);
            4:       return RST_HOLD_TIME;
            5:       return $urandom;
            default: return '1;
        endcase
    endfunction

    // Time step between samples, aimed at the current thresholds
    function automatic logic [STAMP_W-1:0] next_gap();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd1;
            2, 3:    return $urandom_range(2, 40);
            4:       return drv_hold;
            5:       return drv_hold - 32'd1;
            6:       return drv_debounce;
            7:       return drv_debounce - 32'd1;
            8:       return drv_debounce + 32'd1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        sample_t               s;
        logic [CFG_DATA_W-1:0] val;

        // After reset: high level pressed, 20000 us debounce, 500000 us hold, ident 0
        steps.push_back(typed_row(1'b0, 32'd0, EV_NONE, 12'h000, 1'b0));
        steps.push_back(typed_row(1'b1, 32'd100, EV_PRESS, 12'h000, 1'b1));
        steps.push_back(typed_row(1'b1, 32'd500099, EV_NONE, 12'h000, 1'b0));
        steps.push_back(typed_row(1'b1, 32'd500100, EV_HOLD, 12'h000, 1'b0));
        steps.push_back(sample_row(1'b0, 32'd900010));
        steps.push_back(sample_row(1'b1, 32'd900020));     // bounce back to held
        steps.push_back(sample_row(1'b0, 32'd900030));
        steps.push_back(typed_row(1'b0, 32'd920029, EV_NONE, 12'h000, 1'b0));
        steps.push_back(typed_row(1'b0, 32'd920030, EV_RELEASE, 12'h000, 1'b1));
        steps.push_back(typed_row(1'b1, 32'hFFFF_FFF0, EV_PRESS, 12'h000, 1'b1));
        steps.push_back(sample_row(1'b1, 32'h0000_0010));  // stamp wraps past zero
        steps.push_back(sample_row(1'b0, 32'h0000_0020));  // let go before any hold
        steps.push_back(sample_row(1'b1, 32'h0000_0030));  // bounce to held, no hold event
        steps.push_back(sample_row(1'b0, 32'h0000_0040));
        steps.push_back(sample_row(1'b0, 32'h0000_0030));  // stamp runs backwards
        // Low level pressed, zero thresholds, widest identifier; upper junk bits dropped
        steps.push_back(write_row(CFG_PRESS_LEVEL, 32'hFFFF_FFFE));
        steps.push_back(write_row(CFG_DEBOUNCE_TIME, 32'd0));
        steps.push_back(write_row(CFG_HOLD_TIME, 32'd0));
        steps.push_back(write_row(CFG_BUTTON_IDENT, 32'hFFFF_FFFF));
        steps.push_back(typed_row(1'b1, 32'd5, EV_NONE, 12'hFFF, 1'b0));
        steps.push_back(typed_row(1'b0, 32'd6, EV_PRESS, 12'hFFF, 1'b1));
        steps.push_back(typed_row(1'b0, 32'd6, EV_HOLD, 12'hFFF, 1'b0));
        steps.push_back(sample_row(1'b1, 32'd7));
        steps.push_back(typed_row(1'b1, 32'd7, EV_RELEASE, 12'hFFF, 1'b1));
        // Largest thresholds
        steps.push_back(write_row(CFG_PRESS_LEVEL, 32'd1));
        steps.push_back(write_row(CFG_DEBOUNCE_TIME, 32'hFFFF_FFFF));
        steps.push_back(write_row(CFG_HOLD_TIME, 32'hFFFF_FFFF));
        steps.push_back(write_row(CFG_BUTTON_IDENT, 32'h0000_0A5A));
        steps.push_back(sample_row(1'b1, 32'd0));
        steps.push_back(sample_row(1'b1, 32'hFFFF_FFFE));
        steps.push_back(sample_row(1'b1, 32'hFFFF_FFFF));
        steps.push_back(sample_row(1'b0, 32'd5));
        steps.push_back(sample_row(1'b0, 32'd4));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (steps[i])
        begin
            if (steps[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(steps[i].reg_index, steps[i].reg_value);
            end
            else
                push_sample(steps[i].sample, steps[i].typed, steps[i].want);
        end

        // Random button traffic, one setting and one idling mix per block
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            wait_drained();
            case (blk % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            val = $urandom;
            case (blk)
                0:
                begin
                    val[0] = 1'b0;
                    write_reg(CFG_PRESS_LEVEL, val);
                    write_reg(CFG_DEBOUNCE_TIME, '0);
                    write_reg(CFG_HOLD_TIME, '0);
                    write_reg(CFG_BUTTON_IDENT, {20'($urandom_range(0, 1048575)), 12'h000});
                end
                1:
                begin
                    val[0] = 1'b1;
                    write_reg(CFG_PRESS_LEVEL, val);
                    write_reg(CFG_DEBOUNCE_TIME, '1);
                    write_reg(CFG_HOLD_TIME, '1);
                    write_reg(CFG_BUTTON_IDENT, {20'($urandom_range(0, 1048575)), 12'hFFF});
                end
                default:
                begin
                    write_reg(CFG_PRESS_LEVEL, val);
                    write_reg(CFG_DEBOUNCE_TIME, pick_span());
                    write_reg(CFG_HOLD_TIME, pick_span());
                    write_reg(CFG_BUTTON_IDENT, $urandom);
                end
            endcase

            for (int i = 0; i < BLOCK_ITEMS; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: any level, any stamp
                    s.pin_level = 1'($urandom_range(0, 1));
                    s.now_us    = $urandom;
                    drv_clock   = s.now_us;
                end
                else
                begin
                    // plausible button: runs of one level with bounces
                    if ($urandom_range(0, 99) < 25)
                        drv_pressed = ~drv_pressed;
                    drv_clock   = drv_clock + next_gap();
                    s.pin_level = drv_pressed ^ ~drv_high;
                    s.now_us    = drv_clock;
                end
                push_sample(s, 1'b0, '0);
                if (i == BLOCK_ITEMS / 2)
                    wait_drained();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("button_press_hold_debounce_top verification clean");
        else
            $display("button_press_hold_debounce_top verification failed");
        $finish;
    end

endmodule

// ===== button_press_hold_debounce_top.f =====
design/bphd_pkg.sv
design/bphd_fsm.sv
design/button_press_hold_debounce_top.sv
bench/testbench.sv
